[sv/cone_mesh_triangle_generator_assert.svh]
// Assertion macros shared by the cone mesh triangle generator RTL.
`ifndef CONE_MESH_TRIANGLE_GENERATOR_ASSERT_SVH
`define CONE_MESH_TRIANGLE_GENERATOR_ASSERT_SVH

// Same-cycle implication check.
`define CMTG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmtg: same-cycle check failed");

// Next-cycle implication check.
`define CMTG_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmtg: next-cycle check failed");

`endif

[sv/cmtg_pkg.sv]
// Shared types, constants and the sine table builder for the cone mesh generator.
`default_nettype none

package cmtg_pkg;

   localparam int MAX_SLICES      = 1024;
   localparam int MAX_STACKS      = 1024;
   localparam int SINE_TABLE_BITS = 10;

   localparam int ROM_N     = 1 << SINE_TABLE_BITS;
   localparam int ROM_DEPTH = ROM_N + 1;
   localparam int ROM_AW    = SINE_TABLE_BITS + 1;

   localparam int FRAC_W   = 16;
   localparam int SINE_W   = FRAC_W + 1;
   localparam int PHASE_W  = 16;
   localparam int QUAD_LSB = PHASE_W - 2;
   localparam int RAD_W    = 31;
   localparam int COUNT_W  = 11;
   localparam int IDX_W    = 10;
   localparam int COORD_W  = 32;
   localparam int PROD_W   = RAD_W + SINE_W;
   localparam int MIN_SLICES = 3;

   localparam logic [RAD_W-1:0]   HEIGHT_MAX = '1;
   localparam logic [PHASE_W-1:0] QUARTER    = PHASE_W'(1 << QUAD_LSB);

   // CSR map
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS_STEP = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT_STEP = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SLICE_COUNT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STACK_COUNT = 3'd5;

   localparam logic [RAD_W-1:0]   RADIUS_RST      = 31'd65536;
   localparam logic [RAD_W-1:0]   RADIUS_STEP_RST = 31'd65536;
   localparam logic [RAD_W-1:0]   HEIGHT_STEP_RST = 31'd65536;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 16'd4096;
   localparam logic [COUNT_W-1:0] SLICE_COUNT_RST = 11'd16;
   localparam logic [COUNT_W-1:0] STACK_COUNT_RST = 11'd1;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] stack_index;
      logic [IDX_W-1:0] slice_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
      logic                      last;
      logic                      bad;
   } rsp_type;

   typedef struct packed {
      logic [RAD_W-1:0]   radius;
      logic [RAD_W-1:0]   radius_step;
      logic [RAD_W-1:0]   height_step;
      logic [PHASE_W-1:0] phase_step;
      logic [COUNT_W-1:0] slice_count;
      logic [COUNT_W-1:0] stack_count;
   } cfg_type;

   // Ring geometry plus sine magnitudes; trig slot = phase*2 + (cos ? 1 : 0).
   typedef struct packed {
      logic                   valid;
      logic                   side;
      logic                   ok;
      logic [RAD_W-1:0]       rb;
      logic [RAD_W-1:0]       rt;
      logic [RAD_W-1:0]       hb;
      logic [RAD_W-1:0]       ht;
      logic [3:0]             neg;
      logic [3:0][SINE_W-1:0] mag;
   } geo_type;

   // Scaled coordinates; slot = ring*4 + phase*2 + (cos ? 1 : 0).
   typedef struct packed {
      logic                    valid;
      logic                    side;
      logic                    ok;
      logic [RAD_W-1:0]        hb;
      logic [RAD_W-1:0]        ht;
      logic [7:0][COORD_W-1:0] coord;
   } vtx_type;

   typedef logic [SINE_W-1:0] sine_rom_type [ROM_DEPTH];

   // Quarter-wave sine, Q30 Horner series truncated per step, rounded to Q16.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type t;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  u;
      logic [63:0]  s;
      logic [63:0]  one_q30;
      logic [63:0]  half_pi_q30;
      int           k;
      one_q30     = 64'd1 << 30;
      half_pi_q30 = 64'd1686629713;
      for (k = 0; k < ROM_DEPTH; k++) begin
         x  = (64'(k) * half_pi_q30) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         u  = one_q30;
         u  = one_q30 - ((x2 * u) >> 30) / 64'd110;
         u  = one_q30 - ((x2 * u) >> 30) / 64'd72;
         u  = one_q30 - ((x2 * u) >> 30) / 64'd42;
         u  = one_q30 - ((x2 * u) >> 30) / 64'd20;
         u  = one_q30 - ((x2 * u) >> 30) / 64'd6;
         s  = (x * u) >> 30;
         t[k] = SINE_W'((s + 64'd8192) >> 14);
      end
      return t;
   endfunction

   // Table address for a phase: mirror in odd quadrants.
   function automatic logic [ROM_AW-1:0] rom_addr(input logic [PHASE_W-1:0] phase);
      logic [SINE_TABLE_BITS-1:0] idx;
      idx = phase[QUAD_LSB-1 -: SINE_TABLE_BITS];
      return phase[QUAD_LSB] ? (ROM_AW'(ROM_N) - {1'b0, idx}) : {1'b0, idx};
   endfunction

endpackage

`default_nettype wire

[sv/cone_mesh_triangle_generator.sv]
// Top level of the cone mesh triangle generator: pipeline, output beat stage.
//
//   channel   dir   handshake                 payload
//   request   in    start / busy              req_data (func, stack_index, slice_index)
//   result    out   rsp_strobe (no backpres.) rsp_data (three vertices, last, bad)
//   config    in    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A request enters on any edge with start high and busy low. A base request
// leaves busy low; a side request raises busy for the following cycle, so it
// leaves a free slot for its second result beat.
// The first result beat passes the geometry and scaling stages and the output beat
// register; the second beat of a side request follows in the next cycle.
// Synchronous active-high reset empties the pipeline and restores the CSR
// reset values. The receiver takes every beat; nothing in here ever stalls.
`default_nettype none
`include "cone_mesh_triangle_generator_assert.svh"

module cone_mesh_triangle_generator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output logic                                 busy,
   input  cmtg_pkg::req_type                    req_data,
   // result
   output logic                                 rsp_strobe,
   output cmtg_pkg::rsp_type                    rsp_data,
   // configuration
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cmtg_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);

   cmtg_pkg::cfg_type  cfg;
   cmtg_pkg::geo_type  geo;
   cmtg_pkg::vtx_type  vtx;

   logic               accept;
   logic               busy_ff, busy_in;

   // output beat stage
   logic               rsp_strobe_ff, rsp_strobe_in;
   cmtg_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic               pend_ff, pend_in;        // second side triangle waiting
   cmtg_pkg::rsp_type  hold_ff, hold_in;

   cmtg_pkg::rsp_type  tri_base;
   cmtg_pkg::rsp_type  tri_side1;
   cmtg_pkg::rsp_type  tri_side2;
   cmtg_pkg::rsp_type  beat_bad;
   logic [cmtg_pkg::COORD_W-1:0] y_bot;
   logic [cmtg_pkg::COORD_W-1:0] y_top;

   // ---------------------------------------------------------------
   // Intake. A side request blocks the next cycle so its second
   // triangle has an empty pipeline slot to leave in.
   // ---------------------------------------------------------------
   assign accept  = start && !busy_ff;
   assign busy_in = accept && req_data.func;
   assign busy    = busy_ff;

   cmtg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stages 1-3: checks, phase and ring products, ring clamps, sine table
   cmtg_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .req      (req_data),
      .cfg      (cfg),
      .geo      (geo)
   );

   // stages 4-5: r * sin / r * cos, rounding
   cmtg_scale u_scale (
      .clock (clock),
      .reset (reset),
      .geo   (geo),
      .vtx   (vtx)
   );

   // ---------------------------------------------------------------
   // Triangle assembly. Coordinate slots: ring*4 + phase*2 + cos.
   //   base:   (R @ p1, R @ p0, origin)
   //   side 1: (B @ p0, T @ p1, T @ p0)
   //   side 2: (B @ p0, B @ p1, T @ p1)
   // ---------------------------------------------------------------
   always_comb begin
      y_bot = cmtg_pkg::COORD_W'(vtx.hb);
      y_top = cmtg_pkg::COORD_W'(vtx.ht);

      tri_base      = '0;
      tri_base.a_x  = vtx.coord[2];
      tri_base.a_y  = y_bot;
      tri_base.a_z  = vtx.coord[3];
      tri_base.b_x  = vtx.coord[0];
      tri_base.b_y  = y_bot;
      tri_base.b_z  = vtx.coord[1];
      tri_base.last = 1'b1;

      tri_side1      = '0;
      tri_side1.a_x  = vtx.coord[0];
      tri_side1.a_y  = y_bot;
      tri_side1.a_z  = vtx.coord[1];
      tri_side1.b_x  = vtx.coord[6];
      tri_side1.b_y  = y_top;
      tri_side1.b_z  = vtx.coord[7];
      tri_side1.c_x  = vtx.coord[4];
      tri_side1.c_y  = y_top;
      tri_side1.c_z  = vtx.coord[5];

      tri_side2      = '0;
      tri_side2.a_x  = vtx.coord[0];
      tri_side2.a_y  = y_bot;
      tri_side2.a_z  = vtx.coord[1];
      tri_side2.b_x  = vtx.coord[2];
      tri_side2.b_y  = y_bot;
      tri_side2.b_z  = vtx.coord[3];
      tri_side2.c_x  = vtx.coord[6];
      tri_side2.c_y  = y_top;
      tri_side2.c_z  = vtx.coord[7];
      tri_side2.last = 1'b1;

      // rejected request: one zeroed beat
      beat_bad      = '0;
      beat_bad.last = 1'b1;
      beat_bad.bad  = 1'b1;
   end

   // ---------------------------------------------------------------
   // Output beat register. A fresh item always wins; the held second
   // side triangle goes out in the bubble that busy created.
   // ---------------------------------------------------------------
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pend_in       = 1'b0;
      hold_in       = hold_ff;
      if (vtx.valid) begin
         rsp_strobe_in = 1'b1;
         hold_in       = tri_side2;
         if (!vtx.ok) begin
            rsp_data_in = beat_bad;
         end else if (vtx.side) begin
            rsp_data_in = tri_side1;
            pend_in     = 1'b1;
         end else begin
            rsp_data_in = tri_base;
         end
      end else if (pend_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_data_in   = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // held second triangle never collides with a new item at the output stage
   `CMTG_ASSERT_IMP(a_pend_slot_free, clock, reset, pend_ff, !vtx.valid)
   // a beat without last is always followed by the closing good beat
   `CMTG_ASSERT_NXT(a_pair_closes, clock, reset, rsp_strobe && !rsp_data.last, rsp_strobe && rsp_data.last && !rsp_data.bad)
   // a rejected request yields a single zeroed beat
   `CMTG_ASSERT_IMP(a_bad_zeroed, clock, reset, rsp_strobe && rsp_data.bad, rsp_data.last && rsp_data.a_x == 0 && rsp_data.b_z == 0 && rsp_data.c_y == 0)

endmodule

`default_nettype wire

[sv/cmtg_sine_rom.sv]
// Quarter-wave sine table with two registered read ports.
`default_nettype none

module cmtg_sine_rom (
   input  wire logic                        clock,
   input  wire logic [cmtg_pkg::ROM_AW-1:0] rd_addr_a,
   input  wire logic [cmtg_pkg::ROM_AW-1:0] rd_addr_b,
   output logic      [cmtg_pkg::SINE_W-1:0] rd_data_a,
   output logic      [cmtg_pkg::SINE_W-1:0] rd_data_b
);

   localparam cmtg_pkg::sine_rom_type ROM_TABLE = cmtg_pkg::build_sine_rom();

   logic [cmtg_pkg::SINE_W-1:0] rd_data_a_ff;
   logic [cmtg_pkg::SINE_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      rd_data_a_ff <= ROM_TABLE[rd_addr_a];
      rd_data_b_ff <= ROM_TABLE[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

[sv/cmtg_csr.sv]
// APB configuration registers for the cone mesh generator.
`default_nettype none

module cmtg_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cmtg_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   output cmtg_pkg::cfg_type                    cfg
);

   cmtg_pkg::cfg_type cfg_ff;
   cmtg_pkg::cfg_type cfg_in;

   logic                              wr_en;
   logic [cmtg_pkg::REG_IDX_W-1:0]    reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[cmtg_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cmtg_pkg::REG_RADIUS: begin
               cfg_in.radius = pwdata[cmtg_pkg::RAD_W-1:0];
            end
            cmtg_pkg::REG_RADIUS_STEP: begin
               cfg_in.radius_step = pwdata[cmtg_pkg::RAD_W-1:0];
            end
            cmtg_pkg::REG_HEIGHT_STEP: begin
               cfg_in.height_step = pwdata[cmtg_pkg::RAD_W-1:0];
            end
            cmtg_pkg::REG_PHASE_STEP: begin
               cfg_in.phase_step = pwdata[cmtg_pkg::PHASE_W-1:0];
            end
            cmtg_pkg::REG_SLICE_COUNT: begin
               cfg_in.slice_count = pwdata[cmtg_pkg::COUNT_W-1:0];
            end
            cmtg_pkg::REG_STACK_COUNT: begin
               cfg_in.stack_count = pwdata[cmtg_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius      <= cmtg_pkg::RADIUS_RST;
         cfg_ff.radius_step <= cmtg_pkg::RADIUS_STEP_RST;
         cfg_ff.height_step <= cmtg_pkg::HEIGHT_STEP_RST;
         cfg_ff.phase_step  <= cmtg_pkg::PHASE_STEP_RST;
         cfg_ff.slice_count <= cmtg_pkg::SLICE_COUNT_RST;
         cfg_ff.stack_count <= cmtg_pkg::STACK_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         cmtg_pkg::REG_RADIUS:      prdata = 32'(cfg_ff.radius);
         cmtg_pkg::REG_RADIUS_STEP: prdata = 32'(cfg_ff.radius_step);
         cmtg_pkg::REG_HEIGHT_STEP: prdata = 32'(cfg_ff.height_step);
         cmtg_pkg::REG_PHASE_STEP:  prdata = 32'(cfg_ff.phase_step);
         cmtg_pkg::REG_SLICE_COUNT: prdata = 32'(cfg_ff.slice_count);
         cmtg_pkg::REG_STACK_COUNT: prdata = 32'(cfg_ff.stack_count);
         default:                   prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

[sv/cmtg_geom.sv]
// Front stages: range check, phases, ring radii and heights, sine lookup.
`default_nettype none

module cmtg_geom (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  cmtg_pkg::req_type      req,
   input  cmtg_pkg::cfg_type      cfg,
   output cmtg_pkg::geo_type      geo
);

   localparam int PP_W   = cmtg_pkg::IDX_W + cmtg_pkg::PHASE_W;
   localparam int DROP_W = cmtg_pkg::RAD_W + cmtg_pkg::IDX_W;

   // stage 1: registered request
   logic                          cfg_ok;
   logic                          idx_ok;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_side_ff, s1_side_in;
   logic                          s1_ok_ff, s1_ok_in;
   logic [cmtg_pkg::IDX_W-1:0]    s1_stack_ff, s1_stack_in;
   logic [cmtg_pkg::IDX_W-1:0]    s1_slice_ff, s1_slice_in;

   // stage 2: products
   logic [PP_W-1:0]               phase_prod;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_side_ff, s2_side_in;
   logic                          s2_ok_ff, s2_ok_in;
   logic [cmtg_pkg::PHASE_W-1:0]  s2_p0_ff, s2_p0_in;
   logic [DROP_W-1:0]             s2_rd_ff, s2_rd_in;
   logic [DROP_W-1:0]             s2_hd_ff, s2_hd_in;

   // stage 3: rings and table reads
   logic [DROP_W:0]               rd_next;
   logic [DROP_W:0]               hd_next;
   logic [cmtg_pkg::RAD_W-1:0]    rb_side;
   logic [cmtg_pkg::RAD_W-1:0]    rt_side;
   logic [cmtg_pkg::RAD_W-1:0]    hb_side;
   logic [cmtg_pkg::RAD_W-1:0]    ht_side;
   logic [cmtg_pkg::PHASE_W-1:0]  ph_s0, ph_c0, ph_s1, ph_c1;
   logic                          s3_valid_ff, s3_valid_in;
   logic                          s3_side_ff, s3_side_in;
   logic                          s3_ok_ff, s3_ok_in;
   logic [cmtg_pkg::RAD_W-1:0]    s3_rb_ff, s3_rb_in;
   logic [cmtg_pkg::RAD_W-1:0]    s3_rt_ff, s3_rt_in;
   logic [cmtg_pkg::RAD_W-1:0]    s3_hb_ff, s3_hb_in;
   logic [cmtg_pkg::RAD_W-1:0]    s3_ht_ff, s3_ht_in;
   logic [3:0]                    s3_neg_ff, s3_neg_in;
   logic [cmtg_pkg::SINE_W-1:0]   mag_s0, mag_c0, mag_s1, mag_c1;

   // ---- stage 1
   always_comb begin
      cfg_ok = (cfg.radius != '0) && (cfg.height_step != '0) &&
               (32'(cfg.slice_count) >= 32'(cmtg_pkg::MIN_SLICES)) &&
               (32'(cfg.slice_count) <= 32'(cmtg_pkg::MAX_SLICES)) &&
               (cfg.stack_count != '0) &&
               (32'(cfg.stack_count) <= 32'(cmtg_pkg::MAX_STACKS));
      idx_ok = ({1'b0, req.slice_index} < cfg.slice_count) &&
               (!req.func || ({1'b0, req.stack_index} < cfg.stack_count));
   end

   assign s1_valid_in = in_valid;
   assign s1_side_in  = req.func;
   assign s1_ok_in    = cfg_ok && idx_ok;
   assign s1_stack_in = req.stack_index;
   assign s1_slice_in = req.slice_index;

   // ---- stage 2
   assign phase_prod  = PP_W'(s1_slice_ff) * PP_W'(cfg.phase_step);
   assign s2_valid_in = s1_valid_ff;
   assign s2_side_in  = s1_side_ff;
   assign s2_ok_in    = s1_ok_ff;
   assign s2_p0_in    = phase_prod[cmtg_pkg::PHASE_W-1:0];
   assign s2_rd_in    = DROP_W'(cfg.radius_step) * DROP_W'(s1_stack_ff);
   assign s2_hd_in    = DROP_W'(cfg.height_step) * DROP_W'(s1_stack_ff);

   // ---- stage 3
   always_comb begin
      rd_next = (DROP_W + 1)'(s2_rd_ff) + (DROP_W + 1)'(cfg.radius_step);
      hd_next = (DROP_W + 1)'(s2_hd_ff) + (DROP_W + 1)'(cfg.height_step);

      // radius floors at zero, height saturates
      rb_side = (DROP_W'(cfg.radius) <= s2_rd_ff) ? '0 :
                cfg.radius - s2_rd_ff[cmtg_pkg::RAD_W-1:0];
      rt_side = ((DROP_W + 1)'(cfg.radius) <= rd_next) ? '0 :
                cfg.radius - rd_next[cmtg_pkg::RAD_W-1:0];
      hb_side = (s2_hd_ff > DROP_W'(cmtg_pkg::HEIGHT_MAX)) ? cmtg_pkg::HEIGHT_MAX :
                s2_hd_ff[cmtg_pkg::RAD_W-1:0];
      ht_side = (hd_next > (DROP_W + 1)'(cmtg_pkg::HEIGHT_MAX)) ? cmtg_pkg::HEIGHT_MAX :
                hd_next[cmtg_pkg::RAD_W-1:0];

      ph_s0 = s2_p0_ff;
      ph_c0 = s2_p0_ff + cmtg_pkg::QUARTER;
      ph_s1 = s2_p0_ff + cfg.phase_step;
      ph_c1 = ph_s1 + cmtg_pkg::QUARTER;
   end

   assign s3_valid_in = s2_valid_ff;
   assign s3_side_in  = s2_side_ff;
   assign s3_ok_in    = s2_ok_ff;
   // base disc: full radius at height zero
   assign s3_rb_in    = s2_side_ff ? rb_side : cfg.radius;
   assign s3_rt_in    = rt_side;
   assign s3_hb_in    = s2_side_ff ? hb_side : '0;
   assign s3_ht_in    = ht_side;
   assign s3_neg_in   = {ph_c1[cmtg_pkg::PHASE_W-1], ph_s1[cmtg_pkg::PHASE_W-1],
                         ph_c0[cmtg_pkg::PHASE_W-1], ph_s0[cmtg_pkg::PHASE_W-1]};

   cmtg_sine_rom u_rom_p0 (
      .clock     (clock),
      .rd_addr_a (cmtg_pkg::rom_addr(ph_s0)),
      .rd_addr_b (cmtg_pkg::rom_addr(ph_c0)),
      .rd_data_a (mag_s0),
      .rd_data_b (mag_c0)
   );

   cmtg_sine_rom u_rom_p1 (
      .clock     (clock),
      .rd_addr_a (cmtg_pkg::rom_addr(ph_s1)),
      .rd_addr_b (cmtg_pkg::rom_addr(ph_c1)),
      .rd_data_a (mag_s1),
      .rd_data_b (mag_c1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff  <= s1_side_in;
      s1_ok_ff    <= s1_ok_in;
      s1_stack_ff <= s1_stack_in;
      s1_slice_ff <= s1_slice_in;
      s2_side_ff  <= s2_side_in;
      s2_ok_ff    <= s2_ok_in;
      s2_p0_ff    <= s2_p0_in;
      s2_rd_ff    <= s2_rd_in;
      s2_hd_ff    <= s2_hd_in;
      s3_side_ff  <= s3_side_in;
      s3_ok_ff    <= s3_ok_in;
      s3_rb_ff    <= s3_rb_in;
      s3_rt_ff    <= s3_rt_in;
      s3_hb_ff    <= s3_hb_in;
      s3_ht_ff    <= s3_ht_in;
      s3_neg_ff   <= s3_neg_in;
   end

   always_comb begin
      geo.valid = s3_valid_ff;
      geo.side  = s3_side_ff;
      geo.ok    = s3_ok_ff;
      geo.rb    = s3_rb_ff;
      geo.rt    = s3_rt_ff;
      geo.hb    = s3_hb_ff;
      geo.ht    = s3_ht_ff;
      geo.neg   = s3_neg_ff;
      geo.mag   = {mag_c1, mag_s1, mag_c0, mag_s0};
   end

endmodule

`default_nettype wire

[sv/cmtg_scale.sv]
// Back stages: radius times sine products, then rounding and sign.
`default_nettype none

module cmtg_scale (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cmtg_pkg::geo_type      geo,
   output cmtg_pkg::vtx_type      vtx
);

   localparam logic [cmtg_pkg::PROD_W-1:0] ROUND_HALF =
      cmtg_pkg::PROD_W'(1 << (cmtg_pkg::FRAC_W - 1));

   // stage 4: raw products
   logic                                   s4_valid_ff, s4_valid_in;
   logic                                   s4_side_ff, s4_side_in;
   logic                                   s4_ok_ff, s4_ok_in;
   logic [cmtg_pkg::RAD_W-1:0]             s4_hb_ff, s4_hb_in;
   logic [cmtg_pkg::RAD_W-1:0]             s4_ht_ff, s4_ht_in;
   logic [7:0]                             s4_neg_ff, s4_neg_in;
   logic [7:0][cmtg_pkg::PROD_W-1:0]       s4_prod_ff, s4_prod_in;

   // stage 5: Q16.16 coordinates
   logic [7:0][cmtg_pkg::PROD_W-1:0]       rnd;
   logic                                   s5_valid_ff, s5_valid_in;
   logic                                   s5_side_ff, s5_side_in;
   logic                                   s5_ok_ff, s5_ok_in;
   logic [cmtg_pkg::RAD_W-1:0]             s5_hb_ff, s5_hb_in;
   logic [cmtg_pkg::RAD_W-1:0]             s5_ht_ff, s5_ht_in;
   logic [7:0][cmtg_pkg::COORD_W-1:0]      s5_coord_ff, s5_coord_in;

   assign s4_valid_in = geo.valid;
   assign s4_side_in  = geo.side;
   assign s4_ok_in    = geo.ok;
   assign s4_hb_in    = geo.hb;
   assign s4_ht_in    = geo.ht;

   always_comb begin
      for (int e = 0; e < 8; e++) begin
         s4_neg_in[e]  = geo.neg[e % 4];
         s4_prod_in[e] = cmtg_pkg::PROD_W'((e >= 4) ? geo.rt : geo.rb) *
                         cmtg_pkg::PROD_W'(geo.mag[e % 4]);
      end
   end

   assign s5_valid_in = s4_valid_ff;
   assign s5_side_in  = s4_side_ff;
   assign s5_ok_in    = s4_ok_ff;
   assign s5_hb_in    = s4_hb_ff;
   assign s5_ht_in    = s4_ht_ff;

   // round half away from zero: round the magnitude, then apply sign
   always_comb begin
      for (int e = 0; e < 8; e++) begin
         rnd[e]         = s4_prod_ff[e] + ROUND_HALF;
         s5_coord_in[e] = s4_neg_ff[e] ?
                          -rnd[e][cmtg_pkg::FRAC_W +: cmtg_pkg::COORD_W] :
                           rnd[e][cmtg_pkg::FRAC_W +: cmtg_pkg::COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_side_ff  <= s4_side_in;
      s4_ok_ff    <= s4_ok_in;
      s4_hb_ff    <= s4_hb_in;
      s4_ht_ff    <= s4_ht_in;
      s4_neg_ff   <= s4_neg_in;
      s4_prod_ff  <= s4_prod_in;
      s5_side_ff  <= s5_side_in;
      s5_ok_ff    <= s5_ok_in;
      s5_hb_ff    <= s5_hb_in;
      s5_ht_ff    <= s5_ht_in;
      s5_coord_ff <= s5_coord_in;
   end

   always_comb begin
      vtx.valid = s5_valid_ff;
      vtx.side  = s5_side_ff;
      vtx.ok    = s5_ok_ff;
      vtx.hb    = s5_hb_ff;
      vtx.ht    = s5_ht_ff;
      vtx.coord = s5_coord_ff;
   end

endmodule

`default_nettype wire
